// File: rtl/a192_pkg.sv
`timescale 1ns / 1ps

package a192_pkg;

    localparam int          KEY_WORDS   = 6;
    localparam logic [3:0]  LAST_ROUND  = 4'd12;
    localparam logic [7:0]  RCON_FIRST  = 8'h01;
    localparam logic [7:0]  RCON_POLY   = 8'h1b;

    // Where the RotWord/SubWord/Rcon step lands among the four words made
    // per round key: the pattern repeats every three round keys.
    typedef enum logic [1:0] {
        PH_SUB_WORD0 = 2'd0,
        PH_SUB_WORD2 = 2'd1,
        PH_NO_SUB    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] mid;
        logic [63:0] low;
    } key_t;

    typedef struct packed {
        logic [3:0]  round_index;
        logic [63:0] round_key_low;
        logic [63:0] round_key_high;
        logic        last_key;
    } result_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // RotWord then SubWord; byte 0 of a word sits in bits 7:0.
    function automatic logic [31:0] sub_rot(input logic [31:0] w);
        logic [31:0] r;
        r = {w[7:0], w[31:8]};
        return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? RCON_POLY : 8'h00);
    endfunction

endpackage

// File: rtl/aes192_key_expansion.sv
`timescale 1ns / 1ps
// Path: a key is registered in the key queue, then in the round engine, and each of its
//   round keys then in the result queue before it shows on the outputs.
// Throughput: one round key per cycle while the result queue has room; the round engine
//   makes four schedule words per cycle and is the limit.
// Reset (rst_n low, asynchronous): both queues empty, engine idle; full is low.
module aes192_key_expansion #(
    parameter int KEY_QUEUE_DEPTH    = 2,
    parameter int RESULT_QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] key_bytes_low,
    input  logic [63:0] key_bytes_mid,
    input  logic [63:0] key_bytes_high,
    input  logic        pop,
    output logic        empty,
    output logic [3:0]  round_index,
    output logic [63:0] round_key_low,
    output logic [63:0] round_key_high,
    output logic        last_key
);

    localparam int KEY_W = $bits(a192_pkg::key_t);
    localparam int RES_W = $bits(a192_pkg::result_t);

    logic              key_empty;
    logic              key_take;
    logic [KEY_W-1:0]  key_vec;
    a192_pkg::key_t    key_head;
    logic              res_full;
    logic              res_push;
    a192_pkg::result_t res_data;
    logic [RES_W-1:0]  res_vec;
    a192_pkg::result_t res_head;

    // Front: hold incoming keys so a new key transfers while the engine
    // still works on the previous one.
    a192_fifo #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_QUEUE_DEPTH)
    ) u_key_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({key_bytes_high, key_bytes_mid, key_bytes_low}),
        .full    (full),
        .rd_en   (key_take),
        .rd_data (key_vec),
        .empty   (key_empty)
    );

    assign key_head = key_vec;

    // Back: expand one round key per cycle while the result queue has room; load the next key
    // in the same cycle the last round key of the current one leaves.
    a192_round_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (!key_empty),
        .key_data  (key_head),
        .key_take  (key_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue: the engine advances only while it has room, so a stall
    // on pop backs up into the engine and then into the key queue.
    a192_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_vec),
        .empty   (empty)
    );

    assign res_head       = res_vec;
    assign round_index    = res_head.round_index;
    assign round_key_low  = res_head.round_key_low;
    assign round_key_high = res_head.round_key_high;
    assign last_key       = res_head.last_key;

    // A fresh key always starts at round key zero.
    a_first_round: assert property (@(posedge clk) disable iff (!rst_n)
        key_take |=> (!res_push || res_data.round_index == 4'd0))
        else $error("round key after key load is not round zero");

    // Round keys of one key leave the engine in unbroken order.
    a_round_order: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(res_push && !res_data.last_key) && res_push) |->
            (res_data.round_index == $past(res_data.round_index) + 4'd1))
        else $error("round key index skipped or repeated");

    // The last flag marks round twelve and nothing else.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_data.last_key == (res_data.round_index == a192_pkg::LAST_ROUND)))
        else $error("last flag does not match round index");

    // The engine never writes into a full result queue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("round key pushed into full result queue");

endmodule

// File: rtl/a192_fifo.sv
`timescale 1ns / 1ps

module a192_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold storage without reset; validity comes from the count.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/a192_round_engine.sv
`timescale 1ns / 1ps

module a192_round_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    input  a192_pkg::key_t    key_data,
    output logic              key_take,
    input  logic              res_full,
    output logic              res_push,
    output a192_pkg::result_t res_data
);

    logic [31:0]       win_reg [a192_pkg::KEY_WORDS];
    logic [31:0]       win_next [a192_pkg::KEY_WORDS];
    logic              busy_reg, busy_next;
    logic [3:0]        round_reg, round_next;
    logic [7:0]        rcon_reg, rcon_next;
    a192_pkg::phase_t  phase_reg, phase_next;
    logic              advance;
    logic              at_last;
    logic [31:0]       t0, t2, n0, n1, n2, n3;
    logic              use_rcon;
    logic [31:0]       adv_win [a192_pkg::KEY_WORDS];
    a192_pkg::phase_t  adv_phase;

    assign at_last  = (round_reg == a192_pkg::LAST_ROUND);
    assign advance  = busy_reg && !res_full;
    assign res_push = advance;
    assign key_take = key_valid && (!busy_reg || (advance && at_last));

    assign res_data.round_index    = round_reg;
    assign res_data.round_key_low  = {win_reg[1], win_reg[0]};
    assign res_data.round_key_high = {win_reg[3], win_reg[2]};
    assign res_data.last_key       = at_last;

    // Four new words per round key, at most one substitution among them.
    always_comb
    begin
        t0 = win_reg[5];
        if (phase_reg == a192_pkg::PH_SUB_WORD0)
        begin
            t0 = a192_pkg::sub_rot(win_reg[5]) ^ {24'h0, rcon_reg};
        end
        n0 = win_reg[0] ^ t0;
        n1 = win_reg[1] ^ n0;
        t2 = n1;
        if (phase_reg == a192_pkg::PH_SUB_WORD2)
        begin
            t2 = a192_pkg::sub_rot(n1) ^ {24'h0, rcon_reg};
        end
        n2 = win_reg[2] ^ t2;
        n3 = win_reg[3] ^ n2;
        use_rcon = (phase_reg == a192_pkg::PH_SUB_WORD0) ||
                   (phase_reg == a192_pkg::PH_SUB_WORD2);
        adv_win[0] = win_reg[4];
        adv_win[1] = win_reg[5];
        adv_win[2] = n0;
        adv_win[3] = n1;
        adv_win[4] = n2;
        adv_win[5] = n3;
    end

    always_comb
    begin
        case (phase_reg)
            a192_pkg::PH_SUB_WORD0: adv_phase = a192_pkg::PH_SUB_WORD2;
            a192_pkg::PH_SUB_WORD2: adv_phase = a192_pkg::PH_NO_SUB;
            a192_pkg::PH_NO_SUB:    adv_phase = a192_pkg::PH_SUB_WORD0;
            default:                adv_phase = a192_pkg::PH_SUB_WORD0;
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        rcon_next  = rcon_reg;
        phase_next = phase_reg;
        win_next   = win_reg;
        if (key_take)
        begin
            busy_next   = 1'b1;
            round_next  = '0;
            rcon_next   = a192_pkg::RCON_FIRST;
            phase_next  = a192_pkg::PH_SUB_WORD0;
            win_next[0] = key_data.low[31:0];
            win_next[1] = key_data.low[63:32];
            win_next[2] = key_data.mid[31:0];
            win_next[3] = key_data.mid[63:32];
            win_next[4] = key_data.high[31:0];
            win_next[5] = key_data.high[63:32];
        end
        else if (advance)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                round_next = round_reg + 4'd1;
                phase_next = adv_phase;
                win_next   = adv_win;
                if (use_rcon)
                begin
                    rcon_next = a192_pkg::gf_double(rcon_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            rcon_reg  <= a192_pkg::RCON_FIRST;
            phase_reg <= a192_pkg::PH_SUB_WORD0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            rcon_reg  <= rcon_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// File: test/aes192_key_expansion_test.sv
`timescale 1ns / 1ps

module aes192_key_expansion_test;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int ROUND_KEYS     = 13;
    localparam int SCHED_WORDS    = 52;
    localparam int KEY_WORDS      = 6;
    localparam int RANDOM_KEYS    = 306;
    localparam int IDLE_PERCENT   = 33;
    localparam int HOLD_OFF_AT    = 60;     // keys sent before the long receiver hold-off
    localparam int HOLD_OFF_LEN   = 250;
    localparam int CALM_FIRST     = 200;    // window of keys with no idling on either side
    localparam int CALM_LAST      = 250;
    localparam int TAIL_CYCLES    = 40;
    localparam int CYCLE_LIMIT    = 200000;
    localparam logic [7:0] SBOX_AFFINE = 8'h63;
    localparam logic [7:0] GF_POLY     = 8'h1b;
    localparam logic [7:0] RCON_START  = 8'h01;

    typedef struct {
        logic [63:0] low;
        logic [63:0] mid;
        logic [63:0] high;
        bit          drain_first;   // hold until every round key in flight has come back
    } cipher_key_t;

    typedef struct {
        logic [3:0]  index;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic        last;
    } round_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] key_bytes_low = '0;
    logic [63:0] key_bytes_mid = '0;
    logic [63:0] key_bytes_high = '0;
    logic        pop = 1'b0;
    logic        empty;
    logic [3:0]  round_index;
    logic [63:0] round_key_low;
    logic [63:0] round_key_high;
    logic        last_key;

    aes192_key_expansion u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .key_bytes_low  (key_bytes_low),
        .key_bytes_mid  (key_bytes_mid),
        .key_bytes_high (key_bytes_high),
        .pop            (pop),
        .empty          (empty),
        .round_index    (round_index),
        .round_key_low  (round_key_low),
        .round_key_high (round_key_high),
        .last_key       (last_key)
    );

    cipher_key_t keys_to_send[$];
    round_key_t  round_keys_due[$];
    logic [7:0]  sub_table [256];

    int  keys_sent = 0;
    int  total_keys = 0;
    int  round_keys_checked = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  calm;

    // Both sides stop idling while this window of keys goes through.
    assign calm = (keys_sent >= CALM_FIRST) && (keys_sent < CALM_LAST);

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Timeout guard: count cycles and give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[aes192_key_expansion] ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("%0t: %s", $realtime, what);
    endtask

    // GF(2^8) multiply modulo the AES polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = '0;
        p   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= p;
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY : 8'h00);
        end
        return acc;
    endfunction

    // Build the S-box from first principles: inverse (x^254, zero maps to zero),
    // then the affine transform.
    function automatic logic [7:0] sbox_entry(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] p;
        logic [7:0] s;
        int         e;
        inv = 8'h01;
        p   = x;
        e   = 254;
        while (e != 0)
        begin
            if (e[0])
                inv = gf_mul(inv, p);
            p = gf_mul(p, p);
            e = e >> 1;
        end
        s = inv ^ SBOX_AFFINE;
        for (int k = 1; k <= 4; k++)
            s ^= (inv << k) | (inv >> (8 - k));
        return s;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
            sub_table[i] = sbox_entry(i[7:0]);
    end

    // Expand one cipher key into its 13 round keys and queue them as due.
    task automatic expand_key(input logic [63:0] lo, input logic [63:0] mid,
                              input logic [63:0] hi);
        logic [31:0] w [SCHED_WORDS];
        logic [31:0] t;
        logic [7:0]  rcon;
        round_key_t  rk;
        w[0] = lo[31:0];
        w[1] = lo[63:32];
        w[2] = mid[31:0];
        w[3] = mid[63:32];
        w[4] = hi[31:0];
        w[5] = hi[63:32];
        rcon = RCON_START;
        for (int i = KEY_WORDS; i < SCHED_WORDS; i++)
        begin
            t = w[i - 1];
            if (i % KEY_WORDS == 0)
            begin
                // rotate bytes down by one, substitute, then fold in the round constant
                t = {t[7:0], t[31:8]};
                t = {sub_table[t[31:24]], sub_table[t[23:16]],
                     sub_table[t[15:8]], sub_table[t[7:0]]};
                t[7:0] ^= rcon;
                rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? GF_POLY : 8'h00);
            end
            w[i] = w[i - KEY_WORDS] ^ t;
        end
        for (int r = 0; r < ROUND_KEYS; r++)
        begin
            rk.index    = r[3:0];
            rk.key_low  = {w[4 * r + 1], w[4 * r]};
            rk.key_high = {w[4 * r + 3], w[4 * r + 2]};
            rk.last     = (r == ROUND_KEYS - 1);
            round_keys_due.push_back(rk);
        end
    endtask

    // Driver: hold each key on the inputs until its transfer, then advance to the next
    // pending key, or idle at random or while that key waits for the drain.
    cipher_key_t next_key;
    bit          key_taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push           <= 1'b0;
            key_bytes_low  <= '0;
            key_bytes_mid  <= '0;
            key_bytes_high <= '0;
        end
        else
        begin
            key_taken = push && !full;
            if (key_taken)
            begin
                expand_key(key_bytes_low, key_bytes_mid, key_bytes_high);
                keys_sent++;
            end
            // A key on offer stays put until the block takes it.
            if (!push || key_taken)
            begin
                if (keys_to_send.size() != 0
                    && !(keys_to_send[0].drain_first && round_keys_due.size() != 0)
                    && (calm || $urandom_range(99, 0) >= IDLE_PERCENT))
                begin
                    next_key = keys_to_send.pop_front();
                    push           <= 1'b1;
                    key_bytes_low  <= next_key.low;
                    key_bytes_mid  <= next_key.mid;
                    key_bytes_high <= next_key.high;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every round key transfer against the oldest one due,
    // and throttle pop, once with a long hold-off so the block backs up.
    round_key_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (round_keys_due.size() == 0)
                begin
                    flag_mismatch($sformatf("round key %0d arrived with none due", round_index));
                end
                else
                begin
                    want = round_keys_due.pop_front();
                    round_keys_checked++;
                    if (round_index !== want.index)
                        flag_mismatch($sformatf("round_index got %0d want %0d",
                                                round_index, want.index));
                    if (round_key_low !== want.key_low)
                        flag_mismatch($sformatf("round %0d round_key_low got %h want %h",
                                                want.index, round_key_low, want.key_low));
                    if (round_key_high !== want.key_high)
                        flag_mismatch($sformatf("round %0d round_key_high got %h want %h",
                                                want.index, round_key_high, want.key_high));
                    if (last_key !== want.last)
                        flag_mismatch($sformatf("round %0d last_key got %b want %b",
                                                want.index, last_key, want.last));
                end
            end

            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else if (!hold_done && keys_sent >= HOLD_OFF_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_OFF_LEN;
                pop       <= 1'b0;
            end
            else
            begin
                pop <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
            end
        end
    end

    task automatic queue_key(input logic [63:0] lo, input logic [63:0] mid,
                             input logic [63:0] hi, input bit drain);
        cipher_key_t k;
        k.low         = lo;
        k.mid         = mid;
        k.high        = hi;
        k.drain_first = drain;
        keys_to_send.push_back(k);
    endtask

    // Random 32-bit word, sometimes a flat or repeated-byte pattern.
    function automatic logic [31:0] pick_word();
        logic [7:0] b;
        b = 8'($urandom_range(255, 0));
        case ($urandom_range(7, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return {4{b}};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        // Directed keys: flat patterns, the standard's example key, single bits,
        // and a repeat to show nothing carries over between keys.
        queue_key(64'h0, 64'h0, 64'h0, 1'b0);
        queue_key('1, '1, '1, 1'b0);
        queue_key(64'h5264_0eda_f7b0_738e, 64'he579_9080_2bf3_10c8,
                  64'h7b6b_2c52_d2ea_f862, 1'b0);
        queue_key(64'h5264_0eda_f7b0_738e, 64'he579_9080_2bf3_10c8,
                  64'h7b6b_2c52_d2ea_f862, 1'b0);
        queue_key({16{4'h5}}, {16{4'h5}}, {16{4'h5}}, 1'b0);
        queue_key({16{4'ha}}, {16{4'ha}}, {16{4'ha}}, 1'b0);
        queue_key(64'h1, 64'h0, 64'h0, 1'b0);
        queue_key(64'h0, 64'h0, 64'h8000_0000_0000_0000, 1'b0);
        queue_key(64'h0, 64'h0, 64'hffff_ffff_0000_0000, 1'b0);
        queue_key(64'h0, 64'h8000_0000_0000_0001, 64'h0, 1'b0);
        queue_key({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, 1'b0);
        queue_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                  64'h0f1e_2d3c_4b5a_6978, 1'b1);
        queue_key(64'h0, 64'h0, 64'h0, 1'b0);
        queue_key('1, '1, '1, 1'b0);

        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            if ($urandom_range(9, 0) < 7)
                queue_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, n == 150);
            else
                queue_key({pick_word(), pick_word()}, {pick_word(), pick_word()},
                          {pick_word(), pick_word()}, n == 150);
        end
        total_keys = keys_to_send.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every key transferred, every round key back, then a tail
        // to catch anything extra the block might still emit.
        wait (keys_sent == total_keys);
        wait (round_keys_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("expanded %0d keys into %0d checked round keys", keys_sent,
                 round_keys_checked);
        $display("included a %0d-cycle result hold-off and a full drain pause",
                 HOLD_OFF_LEN);
        if (error_count == 0)
            $display("[aes192_key_expansion] OK");
        else
            $display("[aes192_key_expansion] ERROR");
        $finish;
    end

endmodule
